[src/event_line_tokenizer_core_macros.svh]
// assertion macros shared by the tokenizer rtl
`ifndef EVENT_LINE_TOKENIZER_CORE_MACROS_SVH
`define EVENT_LINE_TOKENIZER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define ELT_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same cycle implication");
`define ELT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next cycle implication");
`else
`define ELT_ASSERT_IMPLY(label, clk, rst, pre, post)
`define ELT_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

[src/elt_pkg.sv]
package elt_pkg;

   localparam int CHAR_W = 8;
   localparam int POS_W  = 11;
   localparam int PRIO_W = 8;
   localparam int KIND_W = 3;

   localparam logic [POS_W-1:0] LINE_MAX_BYTES = 11'd1024;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PROMPT  = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE  = 8'h27;
   localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DIGIT0  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_DIGIT9  = 8'h39;
   localparam logic [PRIO_W+3:0] PRIO_BASE  = 12'd10;
   localparam logic [PRIO_W+3:0] PRIO_LIMIT = 12'd255;

   typedef enum logic [3:0] {
      PH_START,
      PH_AFTER_PROMPT,
      PH_DIGITS,
      PH_NAME,
      PH_GAP,
      PH_PLAIN,
      PH_AFTER_EQ,
      PH_QPOS,
      PH_QNAMED,
      PH_ERROR
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NAME,
      KIND_POSITIONAL,
      KIND_NAMED,
      KIND_LINE_OK,
      KIND_MALFORMED,
      KIND_OVERLONG
   } kind_type;

   typedef enum logic [1:0] {
      MARK_NONE,
      MARK_DQUOTE,
      MARK_SQUOTE,
      MARK_BRACKET
   } mark_type;

   typedef struct packed {
      kind_type          kind;
      logic [POS_W-1:0]  start_pos;
      logic [POS_W-1:0]  split_pos;
      logic [POS_W-1:0]  end_pos;
      logic [PRIO_W-1:0] prio_value;
      logic              last_of_run;
   } rec_type;

   function automatic mark_type opener_code(input logic [CHAR_W-1:0] c);
      mark_type m;
      case (c)
         CH_DQUOTE: m = MARK_DQUOTE;
         CH_SQUOTE: m = MARK_SQUOTE;
         CH_LBRACK: m = MARK_BRACKET;
         default:   m = MARK_NONE;
      endcase
      return m;
   endfunction

   function automatic logic [CHAR_W-1:0] closer_char(input mark_type m);
      logic [CHAR_W-1:0] c;
      case (m)
         MARK_DQUOTE: c = CH_DQUOTE;
         MARK_SQUOTE: c = CH_SQUOTE;
         default:     c = CH_RBRACK;
      endcase
      return c;
   endfunction

   function automatic phase_type plain_phase(input logic [CHAR_W-1:0] c);
      phase_type p;
      case (c)
         CH_SPACE:  p = PH_GAP;
         CH_EQUALS: p = PH_AFTER_EQ;
         default:   p = PH_PLAIN;
      endcase
      return p;
   endfunction

endpackage

[src/elt_channels.sv]
interface elt_req_if;
   logic                        valid;
   logic                        ready;
   logic [elt_pkg::CHAR_W-1:0]  char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface elt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [elt_pkg::KIND_W-1:0]  record_kind;
   logic [elt_pkg::POS_W-1:0]   start_pos;
   logic [elt_pkg::POS_W-1:0]   split_pos;
   logic [elt_pkg::POS_W-1:0]   end_pos;
   logic [elt_pkg::PRIO_W-1:0]  prio_value;
   logic                        last_of_run;

   modport source (output valid, output record_kind, output start_pos, output split_pos,
                   output end_pos, output prio_value, output last_of_run, input ready);
   modport sink   (input valid, input record_kind, input start_pos, input split_pos,
                   input end_pos, input prio_value, input last_of_run, output ready);
endinterface

[src/event_line_tokenizer_core.sv]
// channel   | dir | beat content
// ----------+-----+--------------------------------------------------
// req_bus   | in  | one line byte (char_code), byte 0 ends the line
// rsp_bus   | out | one token or line-end record
//
// one byte is taken per cycle while ready is high; each byte updates the parser
// state in the cycle it is accepted and pushes zero, one or two records into a
// four-entry record queue; a record can leave on the cycle after its byte is taken
// req_bus.ready drops only while the queue holds more than two records
// synchronous active-high reset returns the parser to line start and empties the queue
`include "event_line_tokenizer_core_macros.svh"

module event_line_tokenizer_core (
   input  logic      clock,
   input  logic      reset,
   elt_req_if.sink   req_bus,
   elt_rsp_if.source rsp_bus
);

   localparam int Q_PTR_W = elt_pkg::Q_PTR_W;
   localparam int Q_CNT_W = elt_pkg::Q_CNT_W;

   elt_pkg::phase_type              phase_ff, phase_in;
   logic [elt_pkg::POS_W-1:0]       byte_pos_ff, byte_pos_in;
   logic [elt_pkg::POS_W-1:0]       token_start_ff, token_start_in;
   logic [elt_pkg::POS_W-1:0]       equals_pos_ff, equals_pos_in;
   logic                            equals_seen_ff, equals_seen_in;
   elt_pkg::mark_type               closing_mark_ff, closing_mark_in;
   logic [elt_pkg::PRIO_W-1:0]      prio_acc_ff, prio_acc_in;
   logic                            overlong_ff, overlong_in;

   elt_pkg::rec_type                q_ff [elt_pkg::Q_DEPTH];
   logic [Q_PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]              q_count_ff, q_count_in;

   logic [elt_pkg::CHAR_W-1:0]      c;
   logic                            req_take, rsp_take;
   logic                            is_nul, at_max, is_digit;
   elt_pkg::mark_type               opener;
   logic [elt_pkg::POS_W-1:0]       pos_next;
   logic [elt_pkg::PRIO_W+3:0]      prio_sum;
   logic [elt_pkg::PRIO_W-1:0]      prio_sat;
   elt_pkg::rec_type                rec0, rec1, line_ok, plain_tok;
   logic [1:0]                      rec_count;
   elt_pkg::rec_type                head;
   logic                            at_line_start;

   assign c         = req_bus.char_code;
   assign req_take  = req_bus.valid && req_bus.ready;
   assign rsp_take  = rsp_bus.valid && rsp_bus.ready;
   assign is_nul    = (c == elt_pkg::CH_NUL);
   assign at_max    = (byte_pos_ff >= elt_pkg::LINE_MAX_BYTES);
   assign is_digit  = (c >= elt_pkg::CH_DIGIT0) && (c <= elt_pkg::CH_DIGIT9);
   assign opener    = elt_pkg::opener_code(c);
   assign pos_next  = byte_pos_ff + 1'b1;
   assign at_line_start = (byte_pos_ff == '0) && (phase_ff == elt_pkg::PH_START);

   // priority digits, saturating
   assign prio_sum  = {4'd0, prio_acc_ff} * elt_pkg::PRIO_BASE
                      + {8'd0, 4'(c - elt_pkg::CH_DIGIT0)};
   assign prio_sat  = (prio_sum > elt_pkg::PRIO_LIMIT) ? 8'hFF : prio_sum[7:0];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (req_take) begin
         if (is_nul) begin
            phase_in = elt_pkg::PH_START;
         end else if (at_max) begin
            phase_in = elt_pkg::PH_ERROR;
         end else begin
            case (phase_ff)
               elt_pkg::PH_START: begin
                  if (c == elt_pkg::CH_PROMPT) phase_in = elt_pkg::PH_AFTER_PROMPT;
                  else if (c == elt_pkg::CH_OPEN) phase_in = elt_pkg::PH_DIGITS;
                  else phase_in = elt_pkg::PH_ERROR;
               end
               elt_pkg::PH_AFTER_PROMPT: begin
                  phase_in = (c == elt_pkg::CH_OPEN) ? elt_pkg::PH_DIGITS
                                                     : elt_pkg::PH_ERROR;
               end
               elt_pkg::PH_DIGITS: begin
                  if (is_digit) phase_in = elt_pkg::PH_DIGITS;
                  else if (c == elt_pkg::CH_PROMPT) phase_in = elt_pkg::PH_NAME;
                  else phase_in = elt_pkg::PH_ERROR;
               end
               elt_pkg::PH_NAME: begin
                  if (c == elt_pkg::CH_SPACE) phase_in = elt_pkg::PH_GAP;
               end
               elt_pkg::PH_GAP: begin
                  if (c == elt_pkg::CH_SPACE) phase_in = elt_pkg::PH_GAP;
                  else if (opener != elt_pkg::MARK_NONE) phase_in = elt_pkg::PH_QPOS;
                  else phase_in = elt_pkg::plain_phase(c);
               end
               elt_pkg::PH_PLAIN: begin
                  phase_in = elt_pkg::plain_phase(c);
               end
               elt_pkg::PH_AFTER_EQ: begin
                  if (opener != elt_pkg::MARK_NONE) phase_in = elt_pkg::PH_QNAMED;
                  else phase_in = elt_pkg::plain_phase(c);
               end
               elt_pkg::PH_QPOS, elt_pkg::PH_QNAMED: begin
                  if (c == elt_pkg::closer_char(closing_mark_ff)) phase_in = elt_pkg::PH_GAP;
               end
               elt_pkg::PH_ERROR: begin
                  phase_in = elt_pkg::PH_ERROR;
               end
               default: begin
                  phase_in = elt_pkg::PH_ERROR;
               end
            endcase
         end
      end
   end

   // token bookkeeping and records
   always_comb begin
      byte_pos_in     = byte_pos_ff;
      token_start_in  = token_start_ff;
      equals_pos_in   = equals_pos_ff;
      equals_seen_in  = equals_seen_ff;
      closing_mark_in = closing_mark_ff;
      prio_acc_in     = prio_acc_ff;
      overlong_in     = overlong_ff;

      line_ok             = '0;
      line_ok.kind        = elt_pkg::KIND_LINE_OK;
      line_ok.end_pos     = byte_pos_ff;
      line_ok.prio_value  = prio_acc_ff;

      plain_tok           = '0;
      plain_tok.kind      = equals_seen_ff ? elt_pkg::KIND_NAMED : elt_pkg::KIND_POSITIONAL;
      plain_tok.start_pos = token_start_ff;
      plain_tok.split_pos = equals_seen_ff ? equals_pos_ff : '0;
      plain_tok.end_pos   = byte_pos_ff;

      rec0      = '0;
      rec1      = '0;
      rec_count = 2'd0;

      if (req_take) begin
         if (is_nul) begin
            byte_pos_in     = '0;
            token_start_in  = '0;
            equals_pos_in   = '0;
            equals_seen_in  = 1'b0;
            closing_mark_in = elt_pkg::MARK_NONE;
            prio_acc_in     = '0;
            overlong_in     = 1'b0;
            if (overlong_ff) begin
               rec0.kind    = elt_pkg::KIND_OVERLONG;
               rec0.end_pos = byte_pos_ff;
               rec_count    = 2'd1;
            end else begin
               case (phase_ff)
                  elt_pkg::PH_START, elt_pkg::PH_AFTER_PROMPT, elt_pkg::PH_GAP: begin
                     rec0      = line_ok;
                     rec_count = 2'd1;
                  end
                  elt_pkg::PH_NAME: begin
                     rec0.kind      = elt_pkg::KIND_NAME;
                     rec0.start_pos = token_start_ff;
                     rec0.end_pos   = byte_pos_ff;
                     rec1           = line_ok;
                     rec_count      = 2'd2;
                  end
                  elt_pkg::PH_PLAIN, elt_pkg::PH_AFTER_EQ: begin
                     rec0      = plain_tok;
                     rec1      = line_ok;
                     rec_count = 2'd2;
                  end
                  elt_pkg::PH_QPOS: begin
                     rec0.kind      = elt_pkg::KIND_POSITIONAL;
                     rec0.start_pos = token_start_ff;
                     rec0.end_pos   = byte_pos_ff;
                     rec1           = line_ok;
                     rec_count      = 2'd2;
                  end
                  elt_pkg::PH_QNAMED: begin
                     rec0.kind      = elt_pkg::KIND_NAMED;
                     rec0.start_pos = token_start_ff;
                     rec0.split_pos = equals_pos_ff;
                     rec0.end_pos   = byte_pos_ff;
                     rec1           = line_ok;
                     rec_count      = 2'd2;
                  end
                  default: begin
                     rec0.kind    = elt_pkg::KIND_MALFORMED;
                     rec0.end_pos = byte_pos_ff;
                     rec_count    = 2'd1;
                  end
               endcase
            end
         end else if (at_max) begin
            overlong_in = 1'b1;
         end else begin
            byte_pos_in = pos_next;
            case (phase_ff)
               elt_pkg::PH_DIGITS: begin
                  if (is_digit) prio_acc_in = prio_sat;
                  else if (c == elt_pkg::CH_PROMPT) token_start_in = pos_next;
               end
               elt_pkg::PH_NAME: begin
                  if (c == elt_pkg::CH_SPACE) begin
                     rec0.kind      = elt_pkg::KIND_NAME;
                     rec0.start_pos = token_start_ff;
                     rec0.end_pos   = byte_pos_ff;
                     rec_count      = 2'd1;
                  end
               end
               elt_pkg::PH_GAP: begin
                  if (c != elt_pkg::CH_SPACE) begin
                     token_start_in  = byte_pos_ff;
                     equals_seen_in  = 1'b0;
                     equals_pos_in   = '0;
                     closing_mark_in = opener;
                     if (opener == elt_pkg::MARK_NONE && c == elt_pkg::CH_EQUALS) begin
                        equals_pos_in  = byte_pos_ff;
                        equals_seen_in = 1'b1;
                     end
                  end
               end
               elt_pkg::PH_PLAIN, elt_pkg::PH_AFTER_EQ: begin
                  if (phase_ff == elt_pkg::PH_AFTER_EQ) closing_mark_in = opener;
                  if (phase_ff == elt_pkg::PH_PLAIN || opener == elt_pkg::MARK_NONE) begin
                     if (c == elt_pkg::CH_SPACE) begin
                        rec0      = plain_tok;
                        rec_count = 2'd1;
                     end else if (c == elt_pkg::CH_EQUALS) begin
                        equals_pos_in  = byte_pos_ff;
                        equals_seen_in = 1'b1;
                     end
                  end
               end
               elt_pkg::PH_QPOS, elt_pkg::PH_QNAMED: begin
                  if (c == elt_pkg::closer_char(closing_mark_ff)) begin
                     closing_mark_in = elt_pkg::MARK_NONE;
                     rec0.kind       = (phase_ff == elt_pkg::PH_QNAMED)
                                       ? elt_pkg::KIND_NAMED : elt_pkg::KIND_POSITIONAL;
                     rec0.start_pos  = token_start_ff;
                     rec0.split_pos  = (phase_ff == elt_pkg::PH_QNAMED) ? equals_pos_ff : '0;
                     rec0.end_pos    = pos_next;
                     rec_count       = 2'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      rec0.last_of_run = (rec_count == 2'd1);
      rec1.last_of_run = 1'b1;
   end

   // record queue
   always_comb begin
      wr_ptr_in  = wr_ptr_ff + Q_PTR_W'(rec_count);
      rd_ptr_in  = rd_ptr_ff + Q_PTR_W'(rsp_take);
      q_count_in = q_count_ff + Q_CNT_W'(rec_count) - Q_CNT_W'(rsp_take);
   end

   assign req_bus.ready = (q_count_ff <= Q_CNT_W'(elt_pkg::Q_DEPTH - 2));

   assign head                = q_ff[rd_ptr_ff];
   assign rsp_bus.valid       = (q_count_ff != '0);
   assign rsp_bus.record_kind = head.kind;
   assign rsp_bus.start_pos   = head.start_pos;
   assign rsp_bus.split_pos   = head.split_pos;
   assign rsp_bus.end_pos     = head.end_pos;
   assign rsp_bus.prio_value  = head.prio_value;
   assign rsp_bus.last_of_run = head.last_of_run;

   always_ff @(posedge clock) begin
      if (rec_count != 2'd0) q_ff[wr_ptr_ff] <= rec0;
      if (rec_count == 2'd2) q_ff[wr_ptr_ff + 1'b1] <= rec1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= elt_pkg::PH_START;
         byte_pos_ff     <= '0;
         token_start_ff  <= '0;
         equals_pos_ff   <= '0;
         equals_seen_ff  <= 1'b0;
         closing_mark_ff <= elt_pkg::MARK_NONE;
         prio_acc_ff     <= '0;
         overlong_ff     <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         q_count_ff      <= '0;
      end else begin
         phase_ff        <= phase_in;
         byte_pos_ff     <= byte_pos_in;
         token_start_ff  <= token_start_in;
         equals_pos_ff   <= equals_pos_in;
         equals_seen_ff  <= equals_seen_in;
         closing_mark_ff <= closing_mark_in;
         prio_acc_ff     <= prio_acc_in;
         overlong_ff     <= overlong_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         q_count_ff      <= q_count_in;
      end
   end

   `ELT_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, q_count_ff <= Q_CNT_W'(elt_pkg::Q_DEPTH))
   `ELT_ASSERT_IMPLY(a_overlong_err, clock, reset, overlong_ff, phase_ff == elt_pkg::PH_ERROR)
   `ELT_ASSERT_IMPLY(a_pos_bound, clock, reset, 1'b1, byte_pos_ff <= elt_pkg::LINE_MAX_BYTES)
   `ELT_ASSERT_NEXT(a_line_clear, clock, reset, req_take && is_nul, at_line_start)

endmodule
